// ===== src/cfru_pkg.sv =====
package cfru_pkg;

  // Frame delimiters
  localparam logic [7:0] HDR1_BYTE = 8'hAA;
  localparam logic [7:0] HDR2_BYTE = 8'h55;
  localparam logic [7:0] TRL1_BYTE = 8'hA0;
  localparam logic [7:0] TRL2_BYTE = 8'h5F;

  // Largest payload in units of eight bytes, and the payload bytes the result carries
  localparam int unsigned MAX_UNITS_DEF = 2;
  localparam int unsigned PLD_BYTES     = 16;

  // Packed widths of the result stream
  localparam int unsigned RES_DATA_W = 168;
  localparam int unsigned RES_USER_W = 2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CHECKSUM = 2'd1,
    STATUS_ADDRESS  = 2'd2,
    STATUS_FRAMING  = 2'd3
  } cfru_status_e;

  typedef struct packed {
    cfru_status_e frame_status;
    logic [1:0]   length_units;
    logic [7:0]   command_code;
    logic [7:0]   dest_address;
    logic [7:0]   port_config;
    logic [7:0]   command_data;
    logic [63:0]  payload_low;
    logic [63:0]  payload_high;
  } cfru_result_t;

endpackage

// ===== src/cfru_in_stage.sv =====
module cfru_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // Take a new byte when the register is empty or drains this cycle
  assign s_axis_tready = !valid_q || advance_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_axis_tdata;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== src/cfru_parser.sv =====
module cfru_parser #(
  parameter int unsigned MaxUnits = cfru_pkg::MAX_UNITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic [7:0]            local_addr_i,
  output logic                  res_valid_o,
  output cfru_pkg::cfru_result_t res_o
);

  import cfru_pkg::*;

  localparam int unsigned PldDepth = 8 * MaxUnits;
  localparam int unsigned IdxW     = $clog2(PldDepth);
  localparam int unsigned CntW     = $clog2(PldDepth + 1);

  typedef enum logic [3:0] {
    ST_HDR1    = 4'd0,
    ST_HDR2    = 4'd1,
    ST_LEN     = 4'd2,
    ST_CMD     = 4'd3,
    ST_DEST    = 4'd4,
    ST_PORT    = 4'd5,
    ST_CDATA   = 4'd6,
    ST_CSUM    = 4'd7,
    ST_PAYLOAD = 4'd8,
    ST_TRL1    = 4'd9,
    ST_TRL2    = 4'd10
  } state_e;

  state_e          state_q, state_d;
  logic [7:0]      sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [7:0] len_q, cmd_q, dest_q, port_q, cdata_q, csum_q;
  logic [7:0] pld_q [PldDepth];
  logic [7:0] pld_full [PLD_BYTES];

  logic [4:0] unit_bytes;
  logic [4:0] cnt_inc;
  logic [7:0] sum_add;
  logic       framing;
  logic       frame_done;
  logic [63:0] pld_low, pld_high;

  assign unit_bytes = {len_q[1:0], 3'b000};
  assign cnt_inc    = 5'(cnt_q) + 5'd1;
  assign sum_add    = sum_q + byte_i;

  always_comb begin
    state_d    = state_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    framing    = 1'b0;
    frame_done = 1'b0;
    unique case (state_q)
      ST_HDR1: begin
        if (byte_i != HDR1_BYTE) begin
          framing = 1'b1;
        end else begin
          state_d = ST_HDR2;
          sum_d   = '0;
          cnt_d   = '0;
        end
      end
      ST_HDR2: begin
        if (byte_i != HDR2_BYTE) begin
          framing = 1'b1;
          state_d = ST_HDR1;
        end else begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        sum_d   = sum_add;
        state_d = ST_CMD;
      end
      ST_CMD: begin
        sum_d   = sum_add;
        state_d = ST_DEST;
      end
      ST_DEST: begin
        sum_d   = sum_add;
        state_d = ST_PORT;
      end
      ST_PORT: begin
        sum_d   = sum_add;
        state_d = ST_CDATA;
      end
      ST_CDATA: begin
        sum_d   = sum_add;
        state_d = ST_CSUM;
      end
      ST_CSUM: begin
        cnt_d = '0;
        if (len_q > 8'(MaxUnits)) begin
          framing = 1'b1;
          state_d = ST_HDR1;
        end else if (len_q == 8'd0) begin
          state_d = ST_TRL1;
        end else begin
          state_d = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        sum_d = sum_add;
        cnt_d = CntW'(cnt_inc);
        if (cnt_inc >= unit_bytes) begin
          state_d = ST_TRL1;
        end
      end
      ST_TRL1: begin
        if (byte_i != TRL1_BYTE) begin
          framing = 1'b1;
          state_d = ST_HDR1;
        end else begin
          state_d = ST_TRL2;
        end
      end
      ST_TRL2: begin
        state_d = ST_HDR1;
        if (byte_i != TRL2_BYTE) begin
          framing = 1'b1;
        end else begin
          frame_done = 1'b1;
        end
      end
      default: begin
        state_d = ST_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HDR1;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
    end
  end

  // Header, checksum and payload bytes
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      case (state_q)
        ST_LEN:     len_q   <= byte_i;
        ST_CMD:     cmd_q   <= byte_i;
        ST_DEST:    dest_q  <= byte_i;
        ST_PORT:    port_q  <= byte_i;
        ST_CDATA:   cdata_q <= byte_i;
        ST_CSUM:    csum_q  <= byte_i;
        ST_PAYLOAD: pld_q[cnt_q[IdxW-1:0]] <= byte_i;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < PLD_BYTES; g++) begin : g_pld
    if (g < PldDepth) begin : g_store
      assign pld_full[g] = (5'(g) < unit_bytes) ? pld_q[g] : 8'h00;
    end else begin : g_none
      assign pld_full[g] = 8'h00;
    end
  end

  // First payload byte lands in the most significant position
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pld_low[63 - 8*i -: 8]  = pld_full[i];
      pld_high[63 - 8*i -: 8] = pld_full[i + 8];
    end
  end

  always_comb begin
    res_o = '0;
    if (framing) begin
      res_o.frame_status = STATUS_FRAMING;
    end else begin
      if (sum_q != csum_q) begin
        res_o.frame_status = STATUS_CHECKSUM;
      end else if (dest_q != local_addr_i) begin
        res_o.frame_status = STATUS_ADDRESS;
      end else begin
        res_o.frame_status = STATUS_OK;
      end
      res_o.length_units = len_q[1:0];
      res_o.command_code = cmd_q;
      res_o.dest_address = dest_q;
      res_o.port_config  = port_q;
      res_o.command_data = cdata_q;
      res_o.payload_low  = pld_low;
      res_o.payload_high = pld_high;
    end
  end

  assign res_valid_o = step_i && (framing || frame_done);

endmodule

// ===== src/cfru_out_stage.sv =====
module cfru_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  cfru_pkg::cfru_result_t res_i,
  output logic                  free_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output cfru_pkg::cfru_result_t res_o
);

  import cfru_pkg::*;

  logic         valid_q, valid_d;
  cfru_result_t res_q;

  // Room for a new result when empty or when the held one leaves now
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign res_o         = res_q;

endmodule

// ===== src/command_frame_receiver_unit.sv =====
// Command frame receiver.
// The slave stream carries one received serial byte per transfer. The block parses
// frames of header AA 55, length, command, destination, port config, command data,
// checksum, 8 * length payload bytes and trailer A0 5F, keeping an 8-bit sum of the
// length to command data and payload bytes. One result transfer leaves on the master
// stream for each completed frame (ok, checksum mismatch or address mismatch, with the
// header fields and the raw payload) and for each byte that breaks the framing
// (framing error, all other fields zero). Other bytes produce no result.
// A byte is registered on acceptance and parsed once the output register has room.
// Throughput: one byte per cycle while the output register can take a result; the parse
// step is one state update and one 8-bit add.
// A result waiting in the output register does not block input while that register
// is being drained; only when it is held by a low m_axis_tready and the input register
// is also full does s_axis_tready drop.
// The user must write the local address through local_addr_we_i / local_addr_wdata_i
// only while the block is idle; the block does not enforce this. Reset clears the
// parser to wait for the first header byte, empties both registers and sets the local
// address to zero; no clearing pass is needed.
module command_frame_receiver_unit #(
  parameter int unsigned MaxUnits = cfru_pkg::MAX_UNITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [7:0] rx_byte
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] length_units, [9:2] command_code, [17:10] dest_address,
  // [25:18] port_config, [33:26] command_data, [97:34] payload_low,
  // [161:98] payload_high, [167:162] zero
  output logic [cfru_pkg::RES_DATA_W-1:0]     m_axis_tdata,
  output logic [cfru_pkg::RES_USER_W-1:0]     m_axis_tuser,   // [1:0] frame_status
  // Local address register
  input  logic                                local_addr_we_i,
  input  logic [7:0]                          local_addr_wdata_i
);

  import cfru_pkg::*;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         out_free;
  logic         advance;
  logic         res_valid;
  cfru_result_t res;
  cfru_result_t out_res;
  logic [7:0]   local_addr_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
    end else if (local_addr_we_i) begin
      local_addr_q <= local_addr_wdata_i;
    end
  end

  // Parse the held byte whenever the output register can take a result
  assign advance = in_valid && out_free;

  cfru_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (advance),
    .valid_o       (in_valid),
    .byte_o        (in_byte)
  );

  cfru_parser #(
    .MaxUnits (MaxUnits)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte),
    .local_addr_i (local_addr_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  cfru_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_valid),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (out_res)
  );

  // Pack the result, first field in the lowest bits
  assign m_axis_tdata = {6'b000000,
                         out_res.payload_high,
                         out_res.payload_low,
                         out_res.command_data,
                         out_res.port_config,
                         out_res.dest_address,
                         out_res.command_code,
                         out_res.length_units};
  assign m_axis_tuser = out_res.frame_status;

endmodule

// ===== tb/tb_command_frame_receiver_unit.sv =====
module tb_command_frame_receiver_unit;
  import cfru_pkg::*;

  // Parser positions of the frame predictor
  typedef enum logic [3:0] {
    PS_SYNC1, PS_SYNC2, PS_LEN, PS_CMD, PS_DEST, PS_PORT, PS_DATA,
    PS_CSUM, PS_PAYLOAD, PS_TRAIL1, PS_TRAIL2
  } parse_pos_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RES_DATA_W-1:0] m_axis_tdata;
  logic [RES_USER_W-1:0] m_axis_tuser;
  logic                  local_addr_we_i = 1'b0;
  logic [7:0]            local_addr_wdata_i = 8'h00;

  // Frame predictor state
  parse_pos_e  ps = PS_SYNC1;
  logic [4:0]  pld_cnt = '0;
  logic [7:0]  sum_acc = '0;
  logic [7:0]  len_b = '0, cmd_b = '0, dest_b = '0, port_b = '0, data_b = '0;
  logic [7:0]  csum_b = '0;
  logic [7:0]  node_addr = '0;
  logic [7:0]  pld_buf [16];

  cfru_result_t pending_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  idle_pct = 0;
  int unsigned  stall_left = 0;

  command_frame_receiver_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tuser       (m_axis_tuser),
    .local_addr_we_i    (local_addr_we_i),
    .local_addr_wdata_i (local_addr_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Give up long after the slowest legal run would have finished
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Pack eight payload bytes, first byte in the top lane, absent bytes zero
  function automatic logic [63:0] pack_payload(input int unsigned base, input int unsigned count);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      v = {v[55:0], (base + i < count) ? pld_buf[base + i] : 8'h00};
    end
    return v;
  endfunction

  // Advance the frame predictor by one byte; return 1 when the byte closes or
  // drops a frame, with the outcome in res
  function automatic bit parse_rx_byte(input logic [7:0] b, output cfru_result_t res);
    bit framing;
    bit done;
    framing = 1'b0;
    done    = 1'b0;
    res     = '0;
    case (ps)
      PS_SYNC1: begin
        if (b != HDR1_BYTE) framing = 1'b1;
        else begin
          ps      = PS_SYNC2;
          sum_acc = '0;
          pld_cnt = '0;
        end
      end
      PS_SYNC2: begin
        if (b != HDR2_BYTE) framing = 1'b1;
        else ps = PS_LEN;
      end
      PS_LEN:  begin len_b  = b; sum_acc += b; ps = PS_CMD;  end
      PS_CMD:  begin cmd_b  = b; sum_acc += b; ps = PS_DEST; end
      PS_DEST: begin dest_b = b; sum_acc += b; ps = PS_PORT; end
      PS_PORT: begin port_b = b; sum_acc += b; ps = PS_DATA; end
      PS_DATA: begin data_b = b; sum_acc += b; ps = PS_CSUM; end
      PS_CSUM: begin
        csum_b  = b;
        pld_cnt = '0;
        if (len_b > MAX_UNITS_DEF) framing = 1'b1;
        else if (len_b == 8'd0) ps = PS_TRAIL1;
        else ps = PS_PAYLOAD;
      end
      PS_PAYLOAD: begin
        pld_buf[pld_cnt[3:0]] = b;
        sum_acc += b;
        pld_cnt += 5'd1;
        if (pld_cnt >= 8 * len_b[1:0]) ps = PS_TRAIL1;
      end
      PS_TRAIL1: begin
        if (b != TRL1_BYTE) framing = 1'b1;
        else ps = PS_TRAIL2;
      end
      PS_TRAIL2: begin
        if (b != TRL2_BYTE) framing = 1'b1;
        else begin
          ps   = PS_SYNC1;
          done = 1'b1;
          // A bad checksum wins over a wrong destination
          if (sum_acc != csum_b) res.frame_status = STATUS_CHECKSUM;
          else if (dest_b != node_addr) res.frame_status = STATUS_ADDRESS;
          else res.frame_status = STATUS_OK;
          res.length_units = len_b[1:0];
          res.command_code = cmd_b;
          res.dest_address = dest_b;
          res.port_config  = port_b;
          res.command_data = data_b;
          res.payload_low  = pack_payload(0, 8 * len_b[1:0]);
          res.payload_high = pack_payload(8, 8 * len_b[1:0]);
        end
      end
      default: ps = PS_SYNC1;
    endcase
    if (framing) begin
      ps  = PS_SYNC1;
      res = '0;
      res.frame_status = STATUS_FRAMING;
    end
    return framing || done;
  endfunction

  // Send one byte; tvalid stays high after the transfer so that a following
  // byte can go back to back
  task automatic push_rx_byte(input logic [7:0] b);
    cfru_result_t r;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    if (parse_rx_byte(b, r)) pending_results.push_back(r);
  endtask

  // Build and send one frame. fill: 0 random payload, 1 all zero, 2 all ones.
  // break_at, if not negative, overwrites that byte of the frame with break_val.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                            input logic [7:0] dest, input logic [7:0] port,
                            input logic [7:0] dat, input bit bad_csum,
                            input int fill, input int break_at,
                            input logic [7:0] break_val);
    logic [7:0] frame_q [$];
    logic [7:0] pl_q [$];
    logic [7:0] sum;
    logic [7:0] pb;
    int         n;
    n   = (len <= MAX_UNITS_DEF) ? 8 * len : 0;
    sum = len + cmd + dest + port + dat;
    for (int i = 0; i < n; i++) begin
      pb = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
      pl_q.push_back(pb);
      sum += pb;
    end
    if (bad_csum) sum ^= 8'($urandom_range(1, 255));
    frame_q = {HDR1_BYTE, HDR2_BYTE, len, cmd, dest, port, dat, sum};
    foreach (pl_q[i]) frame_q.push_back(pl_q[i]);
    frame_q.push_back(TRL1_BYTE);
    frame_q.push_back(TRL2_BYTE);
    if (break_at >= 0 && break_at < frame_q.size()) frame_q[break_at] = break_val;
    foreach (frame_q[i]) push_rx_byte(frame_q[i]);
  endtask

  // Drop tvalid and hold until every outcome has come out, plus the pipeline depth
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the node address only with the parser back at the first header byte
  task automatic set_local_address(input logic [7:0] v);
    while (ps != PS_SYNC1) push_rx_byte(8'h00);
    wait_results_drained();
    local_addr_we_i    <= 1'b1;
    local_addr_wdata_i <= v;
    @(posedge clk_i);
    local_addr_we_i <= 1'b0;
    node_addr = v;
  endtask

  // Mostly well-formed frames with random content, some broken, some noise
  task automatic send_random_frame();
    int         pick;
    logic [7:0] len;
    logic [7:0] dest;
    pick = $urandom_range(0, 99);
    len  = 8'($urandom_range(0, 2));
    dest = ($urandom_range(0, 3) != 0) ? node_addr : 8'($urandom);
    if (pick < 70) begin
      send_frame(len, 8'($urandom), dest, 8'($urandom), 8'($urandom),
                 $urandom_range(0, 9) == 0, 0, -1, 8'h00);
    end else if (pick < 85) begin
      send_frame(len, 8'($urandom), dest, 8'($urandom), 8'($urandom),
                 $urandom_range(0, 9) == 0, 0, $urandom_range(0, 9 + 8 * len),
                 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) push_rx_byte(8'($urandom));
    end
  endtask

  task automatic test_framing_errors();
    idle_pct = 20;
    // bad first header byte, both extremes
    push_rx_byte(8'h00);
    push_rx_byte(8'hFF);
    // bad second header byte; a repeated AA is consumed, not taken as a new start
    push_rx_byte(HDR1_BYTE);
    push_rx_byte(8'h00);
    push_rx_byte(HDR1_BYTE);
    push_rx_byte(HDR1_BYTE);
    // length out of range, dropped at the checksum byte
    send_frame(8'd3, 8'h11, 8'h00, 8'h22, 8'h33, 1'b0, 0, -1, 8'h00);
    send_frame(8'hFF, 8'h11, 8'h00, 8'h22, 8'h33, 1'b0, 0, -1, 8'h00);
    // bad first and bad second trailer byte
    send_frame(8'd0, 8'h44, 8'h00, 8'h55, 8'h66, 1'b0, 0, 8, 8'h00);
    send_frame(8'd1, 8'h44, 8'h00, 8'h55, 8'h66, 1'b0, 0, 17, 8'hFF);
  endtask

  task automatic test_frame_lengths();
    idle_pct = 10;
    // zero length: trailer straight after the checksum byte
    send_frame(8'd0, 8'h00, node_addr, 8'h00, 8'h00, 1'b0, 0, -1, 8'h00);
    send_frame(8'd1, 8'hFF, node_addr, 8'hFF, 8'hFF, 1'b0, 2, -1, 8'h00);
    send_frame(8'd2, 8'h00, node_addr, 8'hA5, 8'h5A, 1'b0, 1, -1, 8'h00);
    send_frame(8'd2, 8'hFF, node_addr, 8'h0F, 8'hF0, 1'b0, 2, -1, 8'h00);
    send_frame(8'd1, 8'h3C, node_addr, 8'hC3, 8'h81, 1'b0, 0, -1, 8'h00);
  endtask

  task automatic test_checksum_address();
    idle_pct = 10;
    set_local_address(8'hFF);
    send_frame(8'd1, 8'h12, 8'hFF, 8'h34, 8'h56, 1'b0, 0, -1, 8'h00);
    send_frame(8'd0, 8'h12, 8'h00, 8'h34, 8'h56, 1'b0, 0, -1, 8'h00);
    send_frame(8'd2, 8'h12, 8'hFF, 8'h34, 8'h56, 1'b1, 0, -1, 8'h00);
    // checksum and destination both wrong
    send_frame(8'd0, 8'h12, 8'h7E, 8'h34, 8'h56, 1'b1, 0, -1, 8'h00);
  endtask

  task automatic test_random_traffic();
    logic [7:0]  addr;
    int unsigned phase_start;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       addr = 8'h00;
        1:       addr = 8'hFF;
        3:       addr = 8'h01;
        default: addr = 8'($urandom);
      endcase
      set_local_address(addr);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 90) begin
        // switch between calm stretches and heavy idling on both sides
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 5;
            default: idle_pct = 30;
          endcase
        end
        send_random_frame();
      end
    end
  endtask

  task automatic test_full_rate();
    int unsigned phase_start;
    set_local_address(8'($urandom));
    idle_pct    = 0;
    phase_start = bytes_sent;
    while (bytes_sent - phase_start < 120) send_random_frame();
  endtask

  // Result side: stall in bursts of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left    <= $urandom_range(0, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every result transfer with the oldest predicted outcome
  always @(posedge clk_i) begin
    cfru_result_t want;
    cfru_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.frame_status = cfru_status_e'(m_axis_tuser[1:0]);
      got.length_units = m_axis_tdata[1:0];
      got.command_code = m_axis_tdata[9:2];
      got.dest_address = m_axis_tdata[17:10];
      got.port_config  = m_axis_tdata[25:18];
      got.command_data = m_axis_tdata[33:26];
      got.payload_low  = m_axis_tdata[97:34];
      got.payload_high = m_axis_tdata[161:98];
      if (pending_results.size() == 0) begin
        $error("result transfer with no frame outcome pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("frame_status", want.frame_status, got.frame_status);
        check_field("length_units", want.length_units, got.length_units);
        check_field("command_code", want.command_code, got.command_code);
        check_field("dest_address", want.dest_address, got.dest_address);
        check_field("port_config", want.port_config, got.port_config);
        check_field("command_data", want.command_data, got.command_data);
        check_field("payload_low", want.payload_low, got.payload_low);
        check_field("payload_high", want.payload_high, got.payload_high);
      end
    end
  end

  initial begin
    foreach (pld_buf[i]) pld_buf[i] = 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_framing_errors();
    test_frame_lengths();
    test_checksum_address();
    test_random_traffic();
    test_full_rate();
    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== command_frame_receiver_unit.f =====
src/cfru_pkg.sv
src/cfru_in_stage.sv
src/cfru_parser.sv
src/cfru_out_stage.sv
src/command_frame_receiver_unit.sv
tb/tb_command_frame_receiver_unit.sv
